FILE: rtl/ctd_pkg.sv
`timescale 1ns / 1ps
package ctd_pkg;
    localparam int MAX_MATCHES_DEF = 8;
    localparam int NOTE_RANGE_DEF  = 128;
    localparam int TEMPLATE_COUNT  = 26;
    localparam int BUF_DEPTH       = 8;
    localparam logic [3:0] MAX_MATCHES_RESET = 4'd8;

    typedef enum logic [1:0] {
        CMD_NOTE_ON  = 2'd0,
        CMD_NOTE_OFF = 2'd1,
        CMD_ALL_OFF  = 2'd2,
        CMD_DETECT   = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [3:0]  root;
        logic [4:0]  pattern;
        logic [2:0]  inversion;
        logic [2:0]  quality;
        logic [2:0]  len;
    } entry_t;

    function automatic logic [2:0] tmpl_len(input logic [4:0] p);
        case (p)
            5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5: tmpl_len = 3'd2;
            5'd6: tmpl_len = 3'd1;
            5'd17, 5'd18, 5'd19: tmpl_len = 3'd4;
            5'd20, 5'd21: tmpl_len = 3'd5;
            default: tmpl_len = 3'd3;
        endcase
    endfunction

    function automatic logic [2:0] tmpl_quality(input logic [4:0] p);
        case (p)
            5'd0, 5'd7, 5'd15, 5'd18, 5'd22: tmpl_quality = 3'd0;
            5'd1, 5'd9, 5'd13, 5'd16, 5'd19, 5'd21, 5'd23: tmpl_quality = 3'd1;
            5'd2, 5'd12: tmpl_quality = 3'd2;
            5'd3, 5'd10, 5'd11: tmpl_quality = 3'd3;
            5'd4, 5'd5, 5'd14: tmpl_quality = 3'd4;
            5'd6: tmpl_quality = 3'd5;
            default: tmpl_quality = 3'd6;
        endcase
    endfunction

    // interval k (0-based) in sorted order
    function automatic logic [3:0] tmpl_iv(input logic [4:0] p, input logic [2:0] k);
        logic [19:0] v;
        case (p)
            5'd0:  v = {4'd0, 4'd0, 4'd0, 4'd7, 4'd4};
            5'd1:  v = {4'd0, 4'd0, 4'd0, 4'd7, 4'd3};
            5'd2:  v = {4'd0, 4'd0, 4'd0, 4'd8, 4'd4};
            5'd3:  v = {4'd0, 4'd0, 4'd0, 4'd6, 4'd3};
            5'd4:  v = {4'd0, 4'd0, 4'd0, 4'd7, 4'd5};
            5'd5:  v = {4'd0, 4'd0, 4'd0, 4'd7, 4'd2};
            5'd6:  v = {4'd0, 4'd0, 4'd0, 4'd0, 4'd7};
            5'd7:  v = {4'd0, 4'd0, 4'd11, 4'd7, 4'd4};
            5'd8:  v = {4'd0, 4'd0, 4'd10, 4'd7, 4'd4};
            5'd9:  v = {4'd0, 4'd0, 4'd10, 4'd7, 4'd3};
            5'd10: v = {4'd0, 4'd0, 4'd10, 4'd6, 4'd3};
            5'd11: v = {4'd0, 4'd0, 4'd9, 4'd6, 4'd3};
            5'd12: v = {4'd0, 4'd0, 4'd10, 4'd8, 4'd4};
            5'd13: v = {4'd0, 4'd0, 4'd11, 4'd7, 4'd3};
            5'd14: v = {4'd0, 4'd0, 4'd10, 4'd7, 4'd5};
            5'd15: v = {4'd0, 4'd0, 4'd9, 4'd7, 4'd4};
            5'd16: v = {4'd0, 4'd0, 4'd9, 4'd7, 4'd3};
            5'd17: v = {4'd0, 4'd10, 4'd7, 4'd4, 4'd2};
            5'd18: v = {4'd0, 4'd11, 4'd7, 4'd4, 4'd2};
            5'd19: v = {4'd0, 4'd10, 4'd7, 4'd3, 4'd2};
            5'd20: v = {4'd10, 4'd7, 4'd5, 4'd4, 4'd2};
            5'd21: v = {4'd10, 4'd7, 4'd5, 4'd3, 4'd2};
            5'd22: v = {4'd0, 4'd0, 4'd7, 4'd4, 4'd2};
            5'd23: v = {4'd0, 4'd0, 4'd7, 4'd3, 4'd2};
            5'd24: v = {4'd0, 4'd0, 4'd10, 4'd6, 4'd4};
            5'd25: v = {4'd0, 4'd0, 4'd10, 4'd8, 4'd4};
            default: v = '0;
        endcase
        case (k)
            3'd0: tmpl_iv = v[3:0];
            3'd1: tmpl_iv = v[7:4];
            3'd2: tmpl_iv = v[11:8];
            3'd3: tmpl_iv = v[15:12];
            3'd4: tmpl_iv = v[19:16];
            default: tmpl_iv = 4'd0;
        endcase
    endfunction

    function automatic logic [11:0] tmpl_mask(input logic [4:0] p);
        logic [11:0] m;
        m = '0;
        for (int k = 0; k < 5; k++)
        begin
            if (3'(k) < tmpl_len(p))
                m[tmpl_iv(p, 3'(k))] = 1'b1;
        end
        tmpl_mask = m;
    endfunction
endpackage

FILE: rtl/ctd_if.sv
`timescale 1ns / 1ps
interface ctd_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [6:0] note;
    modport source (output valid, cmd, note, input ready);
    modport sink   (input valid, cmd, note, output ready);
endinterface

interface ctd_out_if;
    logic       valid;
    logic       ready;
    logic       has_match;
    logic [3:0] root_class;
    logic [4:0] chord_pattern;
    logic [3:0] bass_class;
    logic [2:0] inversion;
    logic [2:0] chord_quality;
    logic [7:0] notes_held;
    logic       last_match;
    modport source (output valid, has_match, root_class, chord_pattern, bass_class,
                    inversion, chord_quality, notes_held, last_match, input ready);
    modport sink   (input valid, has_match, root_class, chord_pattern, bass_class,
                    inversion, chord_quality, notes_held, last_match, output ready);
endinterface

FILE: rtl/chord_template_detector.sv
`timescale 1ns / 1ps
// chord template detector
// in channel: one word per command (cmd, note). note on / note off / all off are
// handled in the idle state and give no result; ready drops only while a detect is
// in progress. detect: the held map is scanned one note per cycle to build the
// ordered pitch classes and the bass. then each pitch class is tried as root: the
// root state builds its interval mask, then one template per cycle is compared,
// paused while an inversion is sought; on a match whose root is not the bass the
// inversion is found by one interval check per cycle. the buffer is ordered by an
// exchange sort, one compare/swap per cycle (at most 28 pairs), then words are
// sent from the output register; each word is loaded only after the last is taken.
// reset clears the held map, the held count, and sets max_matches to 8.
// a stalled receiver holds the output word; the sequencer waits for it and
// accepts no new word until the last result has been taken.
module chord_template_detector #(
    parameter int MAX_MATCHES = ctd_pkg::MAX_MATCHES_DEF,
    parameter int NOTE_RANGE  = ctd_pkg::NOTE_RANGE_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [3:0] cfg_wdata,
    ctd_in_if.sink     in_ch,
    ctd_out_if.source  out_ch
);
    localparam int LIM   = (MAX_MATCHES < ctd_pkg::BUF_DEPTH) ? MAX_MATCHES
                                                              : ctd_pkg::BUF_DEPTH;
    localparam int NW    = $clog2(NOTE_RANGE);
    localparam int NCW   = $clog2(NOTE_RANGE + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_ROOT, S_TMPL, S_INV, S_SORT, S_EMIT, S_WAIT
    } state_t;

    state_t       state_reg;
    logic [127:0] held_reg;
    logic [7:0]   total_reg;
    logic [3:0]   maxm_reg;
    logic [NCW-1:0] n_reg;
    logic [3:0]   mod_reg;          // n mod 12 tracked alongside n
    logic [3:0]   pcs_reg [12];
    logic [3:0]   pcc_reg;
    logic [11:0]  seen_reg;
    logic [3:0]   bass_reg;
    logic         any_reg;
    logic [3:0]   r_reg;
    logic [11:0]  ivm_reg;
    logic [2:0]   ivc_reg;
    logic [4:0]   p_reg;
    logic [2:0]   k_reg;
    logic [3:0]   found_reg;
    logic [3:0]   limit_reg;
    logic [2:0]   a_reg, b_reg;
    ctd_pkg::entry_t buf_reg [8];
    logic [3:0]   e_reg;

    // root interval mask, built from the class set in one go (independent lanes)
    logic [3:0]  root_w;
    logic [11:0] ivm_w;
    logic [2:0]  ivc_w;
    always_comb
    begin
        logic [4:0] s;
        logic [3:0] d;
        root_w = pcs_reg[r_reg];
        ivm_w  = '0;
        for (int c = 1; c < 12; c++)
        begin
            s = {1'b0, root_w} + 5'(c);
            d = (s >= 5'd12) ? 4'(s - 5'd12) : s[3:0];
            ivm_w[c] = seen_reg[d];
        end
        ivc_w = 3'($countones(ivm_w) > 5 ? 6 : $countones(ivm_w));
    end

    logic [3:0] iv_w, modsum_w;
    logic [4:0] sum_w;
    assign iv_w     = ctd_pkg::tmpl_iv(p_reg, k_reg);
    assign sum_w    = {1'b0, root_w} + {1'b0, iv_w};
    assign modsum_w = (sum_w >= 5'd12) ? 4'(sum_w - 5'd12) : sum_w[3:0];

    ctd_pkg::entry_t ea_w, eb_w;
    logic swap_w;
    assign ea_w   = buf_reg[a_reg];
    assign eb_w   = buf_reg[b_reg];
    assign swap_w = (eb_w.inversion < ea_w.inversion) ||
                    (eb_w.inversion == ea_w.inversion && eb_w.len > ea_w.len);

    logic match_w;
    assign match_w = (ctd_pkg::tmpl_len(p_reg) == ivc_w) &&
                     (ctd_pkg::tmpl_mask(p_reg) == ivm_reg);

    assign in_ch.ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            held_reg     <= '0;
            total_reg    <= '0;
            maxm_reg     <= ctd_pkg::MAX_MATCHES_RESET;
            out_ch.valid <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                maxm_reg <= cfg_wdata;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        case (ctd_pkg::cmd_t'(in_ch.cmd))
                            ctd_pkg::CMD_NOTE_ON:
                                if (32'(in_ch.note) < NOTE_RANGE && !held_reg[in_ch.note])
                                begin
                                    held_reg[in_ch.note] <= 1'b1;
                                    total_reg <= total_reg + 8'd1;
                                end
                            ctd_pkg::CMD_NOTE_OFF:
                                if (32'(in_ch.note) < NOTE_RANGE && held_reg[in_ch.note])
                                begin
                                    held_reg[in_ch.note] <= 1'b0;
                                    total_reg <= total_reg - 8'd1;
                                end
                            ctd_pkg::CMD_ALL_OFF:
                            begin
                                held_reg  <= '0;
                                total_reg <= '0;
                            end
                            default:
                            begin
                                limit_reg <= (32'(maxm_reg) > LIM) ? 4'(LIM) : maxm_reg;
                                n_reg     <= '0;
                                mod_reg   <= '0;
                                pcc_reg   <= '0;
                                seen_reg  <= '0;
                                bass_reg  <= '0;
                                any_reg   <= 1'b0;
                                found_reg <= '0;
                                state_reg <= S_SCAN;
                            end
                        endcase
                    end
                end
                S_SCAN:
                begin
                    if (held_reg[n_reg[NW-1:0]])
                    begin
                        if (!any_reg)
                        begin
                            bass_reg <= mod_reg;
                            any_reg  <= 1'b1;
                        end
                        if (!seen_reg[mod_reg])
                        begin
                            seen_reg[mod_reg] <= 1'b1;
                            pcs_reg[pcc_reg]  <= mod_reg;
                            pcc_reg <= pcc_reg + 4'd1;
                        end
                    end
                    n_reg   <= n_reg + 1'b1;
                    mod_reg <= (mod_reg == 4'd11) ? 4'd0 : mod_reg + 4'd1;
                    if (32'(n_reg) == NOTE_RANGE - 1)
                    begin
                        r_reg     <= '0;
                        state_reg <= S_ROOT;
                    end
                end
                S_ROOT:
                begin
                    if (r_reg >= pcc_reg || found_reg >= limit_reg)
                    begin
                        a_reg     <= '0;
                        b_reg     <= 3'd1;
                        state_reg <= (found_reg > 4'd1) ? S_SORT : S_EMIT;
                        e_reg     <= '0;
                    end
                    else
                    begin
                        ivm_reg   <= ivm_w;
                        p_reg     <= '0;
                        state_reg <= S_TMPL;
                    end
                end
                S_TMPL:
                begin
                    if (found_reg >= limit_reg)
                    begin
                        r_reg     <= r_reg + 4'd1;
                        state_reg <= S_ROOT;
                    end
                    else if (match_w)
                    begin
                        buf_reg[found_reg[2:0]] <= '{root: root_w, pattern: p_reg,
                            inversion: 3'd0, quality: ctd_pkg::tmpl_quality(p_reg),
                            len: ctd_pkg::tmpl_len(p_reg)};
                        k_reg     <= '0;
                        if (bass_reg != root_w)
                            state_reg <= S_INV;
                        else
                        begin
                            found_reg <= found_reg + 4'd1;
                            if (32'(p_reg) == ctd_pkg::TEMPLATE_COUNT - 1)
                            begin
                                r_reg     <= r_reg + 4'd1;
                                state_reg <= S_ROOT;
                            end
                            else
                                p_reg <= p_reg + 5'd1;
                        end
                    end
                    else if (32'(p_reg) == ctd_pkg::TEMPLATE_COUNT - 1)
                    begin
                        r_reg     <= r_reg + 4'd1;
                        state_reg <= S_ROOT;
                    end
                    else
                        p_reg <= p_reg + 5'd1;
                end
                S_INV:
                begin
                    if (k_reg < ctd_pkg::tmpl_len(p_reg) && modsum_w == bass_reg)
                        buf_reg[found_reg[2:0]].inversion <= k_reg + 3'd1;
                    if (k_reg >= ctd_pkg::tmpl_len(p_reg) || modsum_w == bass_reg)
                    begin
                        found_reg <= found_reg + 4'd1;
                        if (32'(p_reg) == ctd_pkg::TEMPLATE_COUNT - 1)
                        begin
                            r_reg     <= r_reg + 4'd1;
                            state_reg <= S_ROOT;
                        end
                        else
                        begin
                            p_reg     <= p_reg + 5'd1;
                            state_reg <= S_TMPL;
                        end
                    end
                    else
                        k_reg <= k_reg + 3'd1;
                end
                S_SORT:
                begin
                    if (swap_w)
                    begin
                        buf_reg[a_reg] <= eb_w;
                        buf_reg[b_reg] <= ea_w;
                    end
                    if ({1'b0, b_reg} + 4'd1 >= found_reg)
                    begin
                        if ({1'b0, a_reg} + 4'd2 >= found_reg)
                            state_reg <= S_EMIT;
                        a_reg <= a_reg + 3'd1;
                        b_reg <= a_reg + 3'd2;
                    end
                    else
                        b_reg <= b_reg + 3'd1;
                end
                S_EMIT:
                begin
                    out_ch.valid      <= 1'b1;
                    out_ch.bass_class <= bass_reg;
                    out_ch.notes_held <= total_reg;
                    if (found_reg == 4'd0)
                    begin
                        out_ch.has_match     <= 1'b0;
                        out_ch.root_class    <= '0;
                        out_ch.chord_pattern <= '0;
                        out_ch.inversion     <= '0;
                        out_ch.chord_quality <= '0;
                        out_ch.last_match    <= 1'b1;
                    end
                    else
                    begin
                        out_ch.has_match     <= 1'b1;
                        out_ch.root_class    <= buf_reg[e_reg[2:0]].root;
                        out_ch.chord_pattern <= buf_reg[e_reg[2:0]].pattern;
                        out_ch.inversion     <= buf_reg[e_reg[2:0]].inversion;
                        out_ch.chord_quality <= buf_reg[e_reg[2:0]].quality;
                        out_ch.last_match    <= (e_reg + 4'd1 == found_reg);
                    end
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (out_ch.ready)
                    begin
                        out_ch.valid <= 1'b0;
                        if (out_ch.last_match)
                            state_reg <= S_IDLE;
                        else
                        begin
                            e_reg     <= e_reg + 4'd1;
                            state_reg <= S_EMIT;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // words only leave while waiting
    a_valid_wait: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> state_reg == S_WAIT) else $error("stray output word");
    // no command accepted while a result word is offered
    a_ready_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> !out_ch.valid) else $error("ready during detect");
    // match count never exceeds the limit
    a_found_lim: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg <= 4'(LIM) || state_reg == S_IDLE) else $error("buffer overrun");
endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
module testbench;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 600;     // worst-case detect latency, with margin
    localparam int LONG_HOLD   = 3000;

    // one command word as offered on the input channel
    typedef struct {
        ctd_pkg::cmd_t cmd;
        logic [6:0]    note;
    } cmd_word_t;

    // one chord result word
    typedef struct packed {
        logic       has_match;
        logic [3:0] root_class;
        logic [4:0] chord_pattern;
        logic [3:0] bass_class;
        logic [2:0] inversion;
        logic [2:0] chord_quality;
        logic [7:0] notes_held;
        logic       last_match;
    } chord_word_t;

    typedef struct {
        logic [3:0] root;
        logic [4:0] pattern;
        logic [2:0] inversion;
        logic [2:0] quality;
    } match_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [3:0] cfg_wdata;

    ctd_in_if  in_ch ();
    ctd_out_if out_ch ();

    chord_template_detector dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // chord shapes: interval count, intervals, quality
    int shape_len[ctd_pkg::TEMPLATE_COUNT] = '{2, 2, 2, 2, 2, 2, 1, 3, 3, 3, 3, 3, 3, 3,
                                               3, 3, 3, 4, 4, 4, 5, 5, 3, 3, 3, 3};
    int shape_iv[ctd_pkg::TEMPLATE_COUNT][5] = '{
        '{4, 7, 0, 0, 0}, '{3, 7, 0, 0, 0}, '{4, 8, 0, 0, 0}, '{3, 6, 0, 0, 0},
        '{5, 7, 0, 0, 0}, '{2, 7, 0, 0, 0}, '{7, 0, 0, 0, 0}, '{4, 7, 11, 0, 0},
        '{4, 7, 10, 0, 0}, '{3, 7, 10, 0, 0}, '{3, 6, 10, 0, 0}, '{3, 6, 9, 0, 0},
        '{4, 8, 10, 0, 0}, '{3, 7, 11, 0, 0}, '{5, 7, 10, 0, 0}, '{4, 7, 9, 0, 0},
        '{3, 7, 9, 0, 0}, '{2, 4, 7, 10, 0}, '{2, 4, 7, 11, 0}, '{2, 3, 7, 10, 0},
        '{2, 4, 5, 7, 10}, '{2, 3, 5, 7, 10}, '{2, 4, 7, 0, 0}, '{2, 3, 7, 0, 0},
        '{4, 6, 10, 0, 0}, '{4, 8, 10, 0, 0}};
    int shape_qual[ctd_pkg::TEMPLATE_COUNT] = '{0, 1, 2, 3, 4, 4, 5, 0, 6, 1, 3, 3, 2, 1,
                                                4, 0, 1, 6, 0, 1, 6, 1, 0, 1, 6, 6};

    // model of the block
    logic [127:0] held_notes;
    logic [7:0]   held_count;
    logic [3:0]   match_limit;

    cmd_word_t   pending_words[$];
    chord_word_t chord_expect[$];
    bit          failed;
    int          hold_requests;
    int          cycles;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout at %0t, %0d results still expected", $time, chord_expect.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // interval set of a shape, repaired mod 12
    function automatic logic [11:0] shape_mask(int p);
        logic [11:0] m;
        m = '0;
        for (int k = 0; k < shape_len[p]; k++)
            m[shape_iv[p][k] % 12] = 1'b1;
        return m;
    endfunction

    // update the held map or name the chords for one accepted word
    task automatic predict_chords(cmd_word_t w);
        int          pcs[12];
        int          pc_count;
        logic [11:0] seen;
        int          bass;
        bit          any;
        int          lim;
        int          found;
        int          root;
        int          ivc;
        int          iv;
        logic [11:0] ivm;
        match_t      hits[8];
        match_t      tmp;
        bit          swap;
        chord_word_t r;
        pc_count = 0;
        seen = '0;
        bass = 0;
        any = 0;
        found = 0;
        case (w.cmd)
            ctd_pkg::CMD_NOTE_ON:
            begin
                if (!held_notes[w.note])
                begin
                    held_notes[w.note] = 1'b1;
                    held_count = held_count + 8'd1;
                end
            end
            ctd_pkg::CMD_NOTE_OFF:
            begin
                if (held_notes[w.note])
                begin
                    held_notes[w.note] = 1'b0;
                    held_count = held_count - 8'd1;
                end
            end
            ctd_pkg::CMD_ALL_OFF:
            begin
                held_notes = '0;
                held_count = '0;
            end
            default:
            begin
                lim = (match_limit > 8) ? 8 : int'(match_limit);
                for (int n = 0; n < 128; n++)
                begin
                    if (held_notes[n])
                    begin
                        if (!any)
                        begin
                            bass = n % 12;
                            any = 1;
                        end
                        if (!seen[n % 12])
                        begin
                            seen[n % 12] = 1'b1;
                            pcs[pc_count] = n % 12;
                            pc_count++;
                        end
                    end
                end
                for (int ri = 0; ri < pc_count && found < lim; ri++)
                begin
                    root = pcs[ri];
                    ivm = '0;
                    ivc = 0;
                    for (int n = 0; n < pc_count; n++)
                    begin
                        iv = (pcs[n] + 12 - root) % 12;
                        if (iv != 0)
                        begin
                            ivm[iv] = 1'b1;
                            ivc++;
                        end
                    end
                    for (int p = 0; p < ctd_pkg::TEMPLATE_COUNT && found < lim; p++)
                    begin
                        if (shape_len[p] == ivc && shape_mask(p) == ivm)
                        begin
                            hits[found].root = 4'(root);
                            hits[found].pattern = 5'(p);
                            hits[found].quality = 3'(shape_qual[p]);
                            hits[found].inversion = 3'd0;
                            if (bass != root)
                            begin
                                for (int k = shape_len[p] - 1; k >= 0; k--)
                                begin
                                    if ((root + shape_iv[p][k]) % 12 == bass)
                                        hits[found].inversion = 3'(k + 1);
                                end
                            end
                            found++;
                        end
                    end
                end
                if (found == 0)
                begin
                    r = '0;
                    r.bass_class = 4'(bass);
                    r.notes_held = held_count;
                    r.last_match = 1'b1;
                    chord_expect.push_back(r);
                end
                else
                begin
                    // in-place exchange sort: lower inversion first, then longer shape
                    for (int a = 0; a + 1 < found; a++)
                    begin
                        for (int b = a + 1; b < found; b++)
                        begin
                            swap = (hits[b].inversion < hits[a].inversion) ||
                                   (hits[b].inversion == hits[a].inversion &&
                                    shape_len[hits[b].pattern] > shape_len[hits[a].pattern]);
                            if (swap)
                            begin
                                tmp = hits[a];
                                hits[a] = hits[b];
                                hits[b] = tmp;
                            end
                        end
                    end
                    for (int a = 0; a < found; a++)
                    begin
                        r.has_match = 1'b1;
                        r.root_class = hits[a].root;
                        r.chord_pattern = hits[a].pattern;
                        r.bass_class = 4'(bass);
                        r.inversion = hits[a].inversion;
                        r.chord_quality = hits[a].quality;
                        r.notes_held = held_count;
                        r.last_match = (a + 1 == found);
                        chord_expect.push_back(r);
                    end
                end
            end
        endcase
    endtask

    // driver: bursts of words with random gaps, fed from pending_words
    int burst_left;
    int gap_left;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                predict_chords(pending_words.pop_front());
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_ch.valid <= 1'b0;
                end
                else if (pending_words.size() > 0)
                begin
                    in_ch.valid <= 1'b1;
                    in_ch.cmd <= pending_words[0].cmd;
                    in_ch.note <= pending_words[0].note;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 10);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern that changes now and then, plus a long hold on request
    logic [15:0] stall_pat;
    int          pat_pos;
    int          hold_left;
    int          holds_taken;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (holds_taken != hold_requests)
            begin
                holds_taken <= hold_requests;
                hold_left <= LONG_HOLD;
                out_ch.ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= stall_pat[pat_pos];
                pat_pos <= (pat_pos + 1) % 16;
                if (pat_pos == 15)
                begin
                    case ($urandom_range(0, 3))
                        0: stall_pat <= 16'hffff;
                        1: stall_pat <= 16'($urandom) | 16'h0001;
                        default: stall_pat <= 16'($urandom) | 16'($urandom);
                    endcase
                end
            end
        end
    end

    // monitor: every result word against the oldest expectation
    chord_word_t got;
    chord_word_t want;

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = '{out_ch.has_match, out_ch.root_class, out_ch.chord_pattern,
                    out_ch.bass_class, out_ch.inversion, out_ch.chord_quality,
                    out_ch.notes_held, out_ch.last_match};
            if (chord_expect.size() == 0)
            begin
                $display("%0t: unexpected result word, actual %p", $time, got);
                failed = 1;
            end
            else
            begin
                want = chord_expect.pop_front();
                if (got.has_match !== want.has_match || got.root_class !== want.root_class ||
                    got.chord_pattern !== want.chord_pattern ||
                    got.bass_class !== want.bass_class || got.inversion !== want.inversion ||
                    got.chord_quality !== want.chord_quality ||
                    got.notes_held !== want.notes_held || got.last_match !== want.last_match)
                begin
                    $display("%0t: result mismatch, expected %p actual %p", $time, want, got);
                    failed = 1;
                end
            end
        end
    end

    task automatic queue_word(ctd_pkg::cmd_t c, int n);
        cmd_word_t w;
        w.cmd = c;
        w.note = 7'(n);
        pending_words.push_back(w);
    endtask

    // wait until every word is taken and every result has come, then let the block settle
    task automatic wait_idle();
        while (pending_words.size() > 0 || in_ch.valid || chord_expect.size() > 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic write_limit(logic [3:0] v);
        wait_idle();
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        match_limit = v;
    endtask

    // a well-formed chord: maybe clear, play a shape at some octave, maybe revoice, then detect
    task automatic queue_chord();
        int p;
        int base;
        int n;
        p = $urandom_range(0, ctd_pkg::TEMPLATE_COUNT - 1);
        base = $urandom_range(0, 11) + 12 * $urandom_range(0, 8);
        if ($urandom_range(0, 4) != 0)
            queue_word(ctd_pkg::CMD_ALL_OFF, $urandom_range(0, 127));
        queue_word(ctd_pkg::CMD_NOTE_ON, base);
        for (int k = 0; k < shape_len[p]; k++)
        begin
            n = base + shape_iv[p][k];
            // lift some notes an octave to get inversions
            if ($urandom_range(0, 2) == 0 && n + 12 <= 127)
                n += 12;
            queue_word(ctd_pkg::CMD_NOTE_ON, n);
            if ($urandom_range(0, 5) == 0 && n + 12 <= 127)
                queue_word(ctd_pkg::CMD_NOTE_ON, n + 12);
        end
        if ($urandom_range(0, 5) == 0)
            queue_word(ctd_pkg::CMD_NOTE_OFF, base);
        queue_word(ctd_pkg::CMD_DETECT, $urandom_range(0, 127));
    endtask

    task automatic queue_noise();
        int c;
        c = $urandom_range(0, 9);
        if (c < 4)
            queue_word(ctd_pkg::CMD_NOTE_ON, $urandom_range(0, 127));
        else if (c < 7)
            queue_word(ctd_pkg::CMD_NOTE_OFF, $urandom_range(0, 127));
        else if (c < 8)
            queue_word(ctd_pkg::CMD_ALL_OFF, $urandom_range(0, 127));
        else
            queue_word(ctd_pkg::CMD_DETECT, $urandom_range(0, 127));
    endtask

    task automatic queue_random(int count);
        int target;
        target = pending_words.size() + count;
        while (pending_words.size() < target)
        begin
            if ($urandom_range(0, 3) != 0)
                queue_chord();
            else
                queue_noise();
        end
    endtask

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.cmd = ctd_pkg::CMD_NOTE_ON;
        in_ch.note = '0;
        out_ch.ready = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        rst_n = 1'b0;
        held_notes = '0;
        held_count = '0;
        match_limit = ctd_pkg::MAX_MATCHES_RESET;
        failed = 0;
        hold_requests = 0;
        holds_taken = 0;
        hold_left = 0;
        cycles = 0;
        burst_left = 0;
        gap_left = 0;
        stall_pat = 16'hffff;
        pat_pos = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty detect, extreme notes, c major and its inversion
        queue_word(ctd_pkg::CMD_DETECT, 127);
        queue_word(ctd_pkg::CMD_NOTE_ON, 0);
        queue_word(ctd_pkg::CMD_NOTE_ON, 127);
        queue_word(ctd_pkg::CMD_NOTE_ON, 127);       // already held
        queue_word(ctd_pkg::CMD_DETECT, 0);
        queue_word(ctd_pkg::CMD_NOTE_OFF, 5);        // not held
        queue_word(ctd_pkg::CMD_ALL_OFF, 0);
        queue_word(ctd_pkg::CMD_NOTE_ON, 60);
        queue_word(ctd_pkg::CMD_NOTE_ON, 64);
        queue_word(ctd_pkg::CMD_NOTE_ON, 67);
        queue_word(ctd_pkg::CMD_DETECT, 0);
        queue_word(ctd_pkg::CMD_NOTE_OFF, 60);
        queue_word(ctd_pkg::CMD_NOTE_ON, 72);        // first inversion
        queue_word(ctd_pkg::CMD_DETECT, 0);
        // diminished seventh: symmetric, several roots match; then a second four-note chord
        queue_word(ctd_pkg::CMD_ALL_OFF, 0);
        queue_word(ctd_pkg::CMD_NOTE_ON, 48);
        queue_word(ctd_pkg::CMD_NOTE_ON, 51);
        queue_word(ctd_pkg::CMD_NOTE_ON, 54);
        queue_word(ctd_pkg::CMD_NOTE_ON, 57);
        queue_word(ctd_pkg::CMD_DETECT, 0);
        queue_word(ctd_pkg::CMD_NOTE_OFF, 57);
        queue_word(ctd_pkg::CMD_NOTE_OFF, 51);
        queue_word(ctd_pkg::CMD_NOTE_ON, 52);
        queue_word(ctd_pkg::CMD_NOTE_ON, 56);
        queue_word(ctd_pkg::CMD_DETECT, 0);
        wait_idle();

        // default limit of eight, with a long hold on the result side
        hold_requests++;
        queue_random(60);
        wait_idle();

        write_limit(4'd1);
        queue_word(ctd_pkg::CMD_ALL_OFF, 0);
        queue_word(ctd_pkg::CMD_NOTE_ON, 36);
        queue_word(ctd_pkg::CMD_NOTE_ON, 40);
        queue_word(ctd_pkg::CMD_NOTE_ON, 44);
        queue_word(ctd_pkg::CMD_DETECT, 0);
        queue_random(50);

        write_limit(4'd0);                  // nothing collected: always the no-match word
        queue_random(30);

        write_limit(4'd15);                 // clipped to eight
        queue_random(60);

        write_limit(4'd3);
        queue_random(50);

        write_limit(4'd8);
        queue_random(30);

        wait_idle();
        repeat (SETTLE) @(posedge clk);
        if (!failed && chord_expect.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

FILE: filelist.f
rtl/ctd_pkg.sv
rtl/ctd_if.sv
rtl/chord_template_detector.sv
verif/testbench.sv
